/* rtl/frame_column_centroid_defines.svh */
// ----------------------------------------------------------------------------
// frame_column_centroid_defines.svh
// Assertion macros used by the checker file of the centroid block.
// ----------------------------------------------------------------------------
`ifndef FRAME_COLUMN_CENTROID_DEFINES_SVH
`define FRAME_COLUMN_CENTROID_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked across reset
`define FCC_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// Types and constants of the frame column centroid block.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int FRAME_WIDTH_DEFAULT = 320;
   localparam int PIXEL_W             = 8;
   localparam int TOTAL_W             = 23;
   localparam int SUM_W               = 32;
   localparam int OFFSET_W            = 9;
   localparam int QUEUE_DEPTH         = 2;

   localparam int OFFSET_MIN = -256;
   localparam int OFFSET_MAX = 255;

   localparam logic signed [OFFSET_W-1:0] NO_DOT = -9'sd200;

   typedef struct packed {
      logic [SUM_W-1:0]   weighted_sum;
      logic [TOTAL_W-1:0] weight_total;
   } frame_sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage

/* rtl/frame_column_centroid.sv */
// A frame_end beat reaches rsp_tvalid via queue, divide steps and output register.
// Throughput: one pixel beat per cycle; req_tready drops only while two frames
//   wait for the divider, which produces one quotient bit per cycle.
// Reset: synchronous, active high; clears column counter, sums, queue and output valid.
// ----------------------------------------------------------------------------
// frame_column_centroid
// Horizontal intensity-weighted centroid of a pixel stream, one result per frame.
// ----------------------------------------------------------------------------
module frame_column_centroid #(
   parameter int FRAME_WIDTH = fcc_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] offset (signed), [15:9] zero
   output logic        rsp_tuser    // [0] found
);

   fcc_pkg::queue_status_type q_status;
   fcc_pkg::frame_sums_type   push_data;
   fcc_pkg::frame_sums_type   pop_data;
   logic                      push;
   logic                      pop;
   logic signed [fcc_pkg::OFFSET_W-1:0] offset;

   fcc_front #(
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pixel     (req_tdata),
      .frame_end (req_tlast),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   fcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   fcc_back #(
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .offset    (offset),
      .found     (rsp_tuser)
   );

   assign rsp_tdata = {7'b0, offset};

endmodule

/* rtl/fcc_front.sv */
// ----------------------------------------------------------------------------
// fcc_front
// Pixel accumulator: column counter, total weight, column-weighted sum.
// ----------------------------------------------------------------------------
module fcc_front #(
   parameter int FRAME_WIDTH = fcc_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [fcc_pkg::PIXEL_W-1:0]  pixel,
   input  logic                         frame_end,
   input  fcc_pkg::queue_status_type    q_status,
   output logic                         push,
   output fcc_pkg::frame_sums_type      push_data
);

   localparam int ColW  = (FRAME_WIDTH > 2) ? $clog2(FRAME_WIDTH) : 1;
   localparam int ProdW = ColW + fcc_pkg::PIXEL_W;

   logic [ColW-1:0]              column_ff, column_in;
   logic [fcc_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [fcc_pkg::SUM_W-1:0]    sum_ff, sum_in;

   logic                         accept;
   logic [ColW:0]                column_inc;
   logic [ProdW-1:0]             product;
   logic [fcc_pkg::TOTAL_W:0]    total_add;
   logic [fcc_pkg::SUM_W:0]      sum_add;
   logic [fcc_pkg::TOTAL_W-1:0]  total_sat;
   logic [fcc_pkg::SUM_W-1:0]    sum_sat;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      column_inc = {1'b0, column_ff} + (ColW+1)'(1);
      product    = ProdW'(column_ff) * ProdW'(pixel);
      total_add  = {1'b0, total_ff} + (fcc_pkg::TOTAL_W+1)'(pixel);
      sum_add    = {1'b0, sum_ff} + (fcc_pkg::SUM_W+1)'(product);
      total_sat  = total_add[fcc_pkg::TOTAL_W] ? '1 : total_add[fcc_pkg::TOTAL_W-1:0];
      sum_sat    = sum_add[fcc_pkg::SUM_W] ? '1 : sum_add[fcc_pkg::SUM_W-1:0];

      push                   = accept && frame_end;
      push_data.weight_total = total_sat;
      push_data.weighted_sum = sum_sat;

      column_in = column_ff;
      total_in  = total_ff;
      sum_in    = sum_ff;
      if (accept) begin
         if (frame_end) begin
            column_in = '0;
            total_in  = '0;
            sum_in    = '0;
         end else begin
            column_in = (column_inc >= (ColW+1)'(FRAME_WIDTH)) ? '0 : column_inc[ColW-1:0];
            total_in  = total_sat;
            sum_in    = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         total_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         column_ff <= column_in;
         total_ff  <= total_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

/* rtl/fcc_queue.sv */
// ----------------------------------------------------------------------------
// fcc_queue
// Short FIFO of finished frame sums between accumulator and divider.
// ----------------------------------------------------------------------------
module fcc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fcc_pkg::frame_sums_type    push_data,
   input  logic                       pop,
   output fcc_pkg::frame_sums_type    pop_data,
   output fcc_pkg::queue_status_type  q_status
);

   localparam int Depth = fcc_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 2) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   fcc_pkg::frame_sums_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign q_status.full  = (count_ff == CntW'(Depth));
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !q_status.full;
      do_pop    = pop && !q_status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/fcc_back.sv */
// ----------------------------------------------------------------------------
// fcc_back
// Radix-2 restoring divider, offset from center, clamp, no-dot code for empty frames, output register.
// ----------------------------------------------------------------------------
module fcc_back #(
   parameter int FRAME_WIDTH = fcc_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fcc_pkg::queue_status_type           q_status,
   input  fcc_pkg::frame_sums_type             pop_data,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [fcc_pkg::OFFSET_W-1:0] offset,
   output logic                                found
);

   localparam int SumW  = fcc_pkg::SUM_W;
   localparam int TotW  = fcc_pkg::TOTAL_W;
   localparam int DiffW = SumW + 2;
   localparam int CntW  = $clog2(SumW);

   localparam logic signed [DiffW-1:0] HalfWidth = DiffW'(FRAME_WIDTH / 2);
   localparam logic signed [DiffW-1:0] OffLo     = DiffW'(fcc_pkg::OFFSET_MIN);
   localparam logic signed [DiffW-1:0] OffHi     = DiffW'(fcc_pkg::OFFSET_MAX);

   fcc_pkg::back_state_type state_ff, state_in;

   logic [SumW-1:0]  dvd_ff, dvd_in;
   logic [TotW-1:0]  dvs_ff, dvs_in;
   logic [TotW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             zero_ff, zero_in;
   logic             valid_ff, valid_in;
   logic signed [fcc_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic             found_ff, found_in;

   logic [TotW:0]           rem_shift;
   logic signed [DiffW-1:0] diff;
   logic signed [fcc_pkg::OFFSET_W-1:0] clamped;

   assign out_valid = valid_ff;
   assign offset    = offset_ff;
   assign found     = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcc_pkg::BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      zero_ff   <= zero_in;
      offset_ff <= offset_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in  = state_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      zero_in   = zero_ff;
      valid_in  = valid_ff && !out_ready;
      offset_in = offset_ff;
      found_in  = found_ff;
      pop       = 1'b0;

      rem_shift = {rem_ff, dvd_ff[SumW-1]};
      diff      = HalfWidth - DiffW'({2'b00, dvd_ff});
      if (diff < OffLo) begin
         clamped = fcc_pkg::OFFSET_W'(fcc_pkg::OFFSET_MIN);
      end else if (diff > OffHi) begin
         clamped = fcc_pkg::OFFSET_W'(fcc_pkg::OFFSET_MAX);
      end else begin
         clamped = diff[fcc_pkg::OFFSET_W-1:0];
      end

      case (state_ff)
         fcc_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               dvd_in   = pop_data.weighted_sum;
               dvs_in   = pop_data.weight_total;
               zero_in  = (pop_data.weight_total == '0);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = fcc_pkg::BACK_DIVIDE;
            end
         end
         fcc_pkg::BACK_DIVIDE: begin
            if (rem_shift >= {1'b0, dvs_ff}) begin
               rem_in = TotW'(rem_shift - {1'b0, dvs_ff});
               dvd_in = {dvd_ff[SumW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[TotW-1:0];
               dvd_in = {dvd_ff[SumW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(SumW - 1)) begin
               state_in = fcc_pkg::BACK_DONE;
            end
         end
         fcc_pkg::BACK_DONE: begin
            if (!valid_ff || out_ready) begin
               valid_in  = 1'b1;
               offset_in = zero_ff ? fcc_pkg::NO_DOT : clamped;
               found_in  = !zero_ff;
               state_in  = fcc_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = fcc_pkg::BACK_IDLE;
         end
      endcase
   end

endmodule

/* rtl/fcc_checker.sv */
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks of the frame column centroid, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_column_centroid_defines.svh"

module fcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   `FCC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped")
   `FCC_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed under stall")
   `FCC_ASSERT_NOW(a_no_dot, rsp_tvalid && !rsp_tuser, rsp_tdata[8:0] == fcc_pkg::NO_DOT, "empty frame offset wrong")
   `FCC_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[15:9] == 7'b0, "rsp padding not zero")
   `FCC_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

bind frame_column_centroid fcc_checker u_fcc_checker (.*);
